// ----- src/aamt_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// aamt_pkg: shared types and constants of the aging address map table
// Operation and status codes, field widths, and the controller/datapath link.
// ----------------------------------------------------------------------------
package aamt_pkg;

    localparam int unsigned TABLE_ENTRIES_DEF = 16;

    localparam int unsigned MODE_W  = 2;
    localparam int unsigned HALF_W  = 64;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned DROP_W  = 5;
    localparam int unsigned TICK_W  = 32;
    localparam int unsigned PERIOD_W = 31;

    localparam int unsigned IN_DATA_W  = 264;   // 257 bits of fields, byte padded
    localparam int unsigned OUT_DATA_W = 136;   // 133 bits of fields, byte padded

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 31'd3600;
    localparam logic [DROP_W-1:0]   DROP_MAX     = 5'd31;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SET    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ERASE  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_TICK   = 2'd3;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISS     = 2'd1;
    localparam logic [STAT_W-1:0] ST_CONFLICT = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

    // register word index
    localparam logic [0:0] REG_IDLE_LIMIT = 1'b0;

    typedef struct packed {
        logic capture;   // latch the incoming beat
        logic look;      // key search, value read issued
        logic eval;      // value compare, expiry scan
        logic commit;    // table update and result load
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;  // result register can take a new beat
    } dp_status_t;

endpackage : aamt_pkg
`default_nettype wire

// ----- src/aging_address_map_table.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// aging_address_map_table: server id to address table with idle expiry
// Associative table of TABLE_ENTRIES slots with lookup, set, erase and a
// time tick that sweeps out expiring entries left idle beyond the period.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Beat contents
//  -------   ---------  ---------------------------------------------------
//  s_axis    in         tuser: mode; tdata: id, address, make_expiring
//  m_axis    out        tuser: status; tdata: found address, dropped count
//  APB       in/out     idle period register at byte address 0
//
//  Each beat steps the sequencer through accept, key search with address read,
//  evaluate and commit; its result beat is registered at the commit, so the
//  input takes no new beat until the last one has committed.
//  s_axis_tready is high only while idle. A waiting result sits in the output
//  register; the next commit waits on m_axis_tready.
//  Reset empties the table at once (valid flags in flops); no clearing pass.
//
module aging_address_map_table #(
    parameter int unsigned TABLE_ENTRIES = aamt_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // input beats
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // [63:0] id_high, [127:64] id_low, [191:128] addr_high,
    // [255:192] addr_low, [256] make_expiring, [263:257] zero
    input  wire logic [aamt_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // [1:0] mode
    input  wire logic [aamt_pkg::MODE_W-1:0]        s_axis_tuser,
    // result beats
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [63:0] found_addr_high, [127:64] found_addr_low,
    // [132:128] dropped_count, [135:133] zero
    output logic      [aamt_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // [1:0] status
    output logic      [aamt_pkg::STAT_W-1:0]        m_axis_tuser,
    // configuration
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [2:0]                         paddr,
    input  wire logic [31:0]                        pwdata,
    output logic      [31:0]                        prdata,
    output logic                                    pready
);

    import aamt_pkg::*;

    ctrl_cmd_t           cmd;
    dp_status_t          dp_status;
    logic [PERIOD_W-1:0] period_reg;
    logic                cfg_wr;
    logic [STAT_W-1:0]   res_status;
    logic [HALF_W-1:0]   res_fh;
    logic [HALF_W-1:0]   res_fl;
    logic [DROP_W-1:0]   res_drop;

    // ---- register port: always ready, write on the access phase ----
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == REG_IDLE_LIMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET;
        end
        else if (cfg_wr)
        begin
            period_reg <= pwdata[PERIOD_W-1:0];
        end
    end

    // words other than the period read as zero
    assign prdata = (paddr[2] == REG_IDLE_LIMIT) ? {1'b0, period_reg} : '0;

    // ---- sequencer ----
    aamt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    // ---- table ----
    aamt_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .dp_status       (dp_status),
        .idle_limit      (period_reg),
        .mode            (s_axis_tuser),
        .id_high         (s_axis_tdata[63:0]),
        .id_low          (s_axis_tdata[127:64]),
        .addr_high       (s_axis_tdata[191:128]),
        .addr_low        (s_axis_tdata[255:192]),
        .make_expiring   (s_axis_tdata[256]),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .status          (res_status),
        .found_addr_high (res_fh),
        .found_addr_low  (res_fl),
        .dropped_count   (res_drop)
    );

    assign m_axis_tuser = res_status;
    assign m_axis_tdata = {3'b000, res_drop, res_fl, res_fh};

endmodule : aging_address_map_table
`default_nettype wire

// ----- src/aamt_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// aamt_ram: generic single-write, single-read RAM
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
module aamt_ram #(
    parameter int unsigned WIDTH = 128,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule : aamt_ram
`default_nettype wire

// ----- src/aamt_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// aamt_ctrl: operation sequencer
// Steps each accepted beat through search, evaluate and commit.
// ----------------------------------------------------------------------------
module aamt_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire aamt_pkg::dp_status_t   dp_status,
    output aamt_pkg::ctrl_cmd_t         cmd
);

    import aamt_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_EVAL = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        cmd         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_LOOK;
                end
            end
            S_LOOK:
            begin
                cmd.look   = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                // hold until the result register is free
                if (dp_status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule : aamt_ctrl
`default_nettype wire

// ----- src/aamt_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// aamt_dp: table datapath
// Key CAM, entry flags and stamps in flops, addresses in RAM, result register.
// ----------------------------------------------------------------------------
module aamt_dp #(
    parameter int unsigned TABLE_ENTRIES = aamt_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire aamt_pkg::ctrl_cmd_t                cmd,
    output aamt_pkg::dp_status_t                    dp_status,
    input  wire logic [aamt_pkg::PERIOD_W-1:0]      idle_limit,
    input  wire logic [aamt_pkg::MODE_W-1:0]        mode,
    input  wire logic [aamt_pkg::HALF_W-1:0]        id_high,
    input  wire logic [aamt_pkg::HALF_W-1:0]        id_low,
    input  wire logic [aamt_pkg::HALF_W-1:0]        addr_high,
    input  wire logic [aamt_pkg::HALF_W-1:0]        addr_low,
    input  wire logic                               make_expiring,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic      [aamt_pkg::STAT_W-1:0]        status,
    output logic      [aamt_pkg::HALF_W-1:0]        found_addr_high,
    output logic      [aamt_pkg::HALF_W-1:0]        found_addr_low,
    output logic      [aamt_pkg::DROP_W-1:0]        dropped_count
);

    import aamt_pkg::*;

    localparam int unsigned SLOT_W = $clog2(TABLE_ENTRIES);
    localparam int unsigned CNT_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int unsigned VAL_W  = 2 * HALF_W;

    // captured operation
    logic [MODE_W-1:0] op_reg;
    logic [HALF_W-1:0] id_hi_reg;
    logic [HALF_W-1:0] id_lo_reg;
    logic [HALF_W-1:0] ad_hi_reg;
    logic [HALF_W-1:0] ad_lo_reg;
    logic              mk_reg;

    // table state
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [TABLE_ENTRIES-1:0] valid_next;
    logic [TABLE_ENTRIES-1:0] expires_reg;
    logic [TABLE_ENTRIES-1:0] expires_next;
    logic [HALF_W-1:0]        key_hi_reg [TABLE_ENTRIES];
    logic [HALF_W-1:0]        key_lo_reg [TABLE_ENTRIES];
    logic [TICK_W-1:0]        stamp_reg  [TABLE_ENTRIES];
    logic [TICK_W-1:0]        tick_reg;

    // search results
    logic [TABLE_ENTRIES-1:0] match_vec;
    logic [TABLE_ENTRIES-1:0] match_oh;
    logic [TABLE_ENTRIES-1:0] free_oh;
    logic [SLOT_W-1:0]        match_idx;
    logic [SLOT_W-1:0]        free_idx;
    logic [TABLE_ENTRIES-1:0] match_oh_reg;
    logic [TABLE_ENTRIES-1:0] free_oh_reg;
    logic [SLOT_W-1:0]        free_idx_reg;
    logic                     hit_reg;
    logic                     full_reg;

    // evaluate stage
    logic [VAL_W-1:0]         ram_rd_data;
    logic [VAL_W-1:0]         found_reg;
    logic                     same_reg;
    logic [TABLE_ENTRIES-1:0] aged_vec;
    logic [TABLE_ENTRIES-1:0] aged_reg;
    logic [CNT_W-1:0]         aged_cnt;
    logic [DROP_W-1:0]        drop_cnt;

    // commit
    logic [TABLE_ENTRIES-1:0] stamp_we;
    logic [TABLE_ENTRIES-1:0] key_we;
    logic                     ram_we;
    logic [STAT_W-1:0]        res_status;
    logic [VAL_W-1:0]         res_found;
    logic [DROP_W-1:0]        res_drop;

    // result register
    logic                     out_valid_reg;
    logic [STAT_W-1:0]        out_status_reg;
    logic [HALF_W-1:0]        out_fh_reg;
    logic [HALF_W-1:0]        out_fl_reg;
    logic [DROP_W-1:0]        out_drop_reg;

    assign dp_status.out_free = !out_valid_reg || out_ready;

    // ---- search: parallel key compare, lowest match and lowest free slot ----
    always_comb
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            match_vec[i] = valid_reg[i] && (key_hi_reg[i] == id_hi_reg)
                           && (key_lo_reg[i] == id_lo_reg);
        end
        match_oh = match_vec & (~match_vec + 1'b1);
        free_oh  = ~valid_reg & (valid_reg + 1'b1);
        match_idx = '0;
        free_idx  = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (match_vec[i])
            begin
                match_idx = SLOT_W'(i);
            end
            if (!valid_reg[i])
            begin
                free_idx = SLOT_W'(i);
            end
        end
    end

    // ---- expiry scan, against the already advanced tick ----
    always_comb
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            aged_vec[i] = valid_reg[i] && expires_reg[i]
                          && ({1'b0, idle_limit} < (tick_reg - stamp_reg[i]));
        end
    end

    always_comb
    begin
        aged_cnt = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            aged_cnt = aged_cnt + CNT_W'(aged_reg[i]);
        end
    end

    generate
        if (CNT_W > DROP_W)
        begin : g_sat
            assign drop_cnt = (aged_cnt > CNT_W'(DROP_MAX)) ? DROP_MAX
                                                            : DROP_W'(aged_cnt);
        end
        else
        begin : g_nosat
            assign drop_cnt = DROP_W'(aged_cnt);
        end
    endgenerate

    // ---- address store ----
    aamt_ram #(
        .WIDTH (VAL_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_val_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (free_idx_reg),
        .wr_data ({ad_hi_reg, ad_lo_reg}),
        .rd_addr (match_idx),
        .rd_data (ram_rd_data)
    );

    // ---- commit decision ----
    always_comb
    begin
        valid_next   = valid_reg;
        expires_next = expires_reg;
        stamp_we     = '0;
        key_we       = '0;
        ram_we       = 1'b0;
        res_status   = ST_OK;
        res_found    = '0;
        res_drop     = '0;
        unique case (op_reg)
            MODE_LOOKUP:
            begin
                if (hit_reg)
                begin
                    stamp_we  = match_oh_reg & expires_reg;
                    res_found = found_reg;
                end
                else
                begin
                    res_status = ST_MISS;
                end
            end
            MODE_SET:
            begin
                if (hit_reg)
                begin
                    if (!same_reg)
                    begin
                        res_status = ST_CONFLICT;
                    end
                    else if (!mk_reg)
                    begin
                        expires_next = expires_reg & ~match_oh_reg;
                    end
                    else
                    begin
                        expires_next = expires_reg | match_oh_reg;
                        stamp_we     = match_oh_reg;
                    end
                end
                else if (full_reg)
                begin
                    res_status = ST_FULL;
                end
                else
                begin
                    valid_next   = valid_reg | free_oh_reg;
                    expires_next = mk_reg ? (expires_reg | free_oh_reg)
                                          : (expires_reg & ~free_oh_reg);
                    key_we       = free_oh_reg;
                    stamp_we     = free_oh_reg;
                    ram_we       = cmd.commit;
                end
            end
            MODE_ERASE:
            begin
                if (hit_reg)
                begin
                    valid_next   = valid_reg & ~match_oh_reg;
                    expires_next = expires_reg & ~match_oh_reg;
                end
                else
                begin
                    res_status = ST_MISS;
                end
            end
            MODE_TICK:
            begin
                valid_next   = valid_reg & ~aged_reg;
                expires_next = expires_reg & ~aged_reg;
                res_drop     = drop_cnt;
            end
            default:
            begin
                res_status = ST_OK;
            end
        endcase
    end

    // ---- control state ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            expires_reg   <= '0;
            tick_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.look && (op_reg == MODE_TICK))
            begin
                tick_reg <= tick_reg + 1'b1;
            end
            if (cmd.commit)
            begin
                valid_reg     <= valid_next;
                expires_reg   <= expires_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---- payload ----
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= mode;
            id_hi_reg <= id_high;
            id_lo_reg <= id_low;
            ad_hi_reg <= addr_high;
            ad_lo_reg <= addr_low;
            mk_reg    <= make_expiring;
        end
        if (cmd.look)
        begin
            match_oh_reg <= match_oh;
            free_oh_reg  <= free_oh;
            free_idx_reg <= free_idx;
            hit_reg      <= |match_vec;
            full_reg     <= &valid_reg;
        end
        if (cmd.eval)
        begin
            found_reg <= ram_rd_data;
            same_reg  <= (ram_rd_data == {ad_hi_reg, ad_lo_reg});
            aged_reg  <= aged_vec;
        end
        if (cmd.commit)
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                if (stamp_we[i])
                begin
                    stamp_reg[i] <= tick_reg;
                end
                if (key_we[i])
                begin
                    key_hi_reg[i] <= id_hi_reg;
                    key_lo_reg[i] <= id_lo_reg;
                end
            end
            out_status_reg <= res_status;
            out_fh_reg     <= res_found[VAL_W-1:HALF_W];
            out_fl_reg     <= res_found[HALF_W-1:0];
            out_drop_reg   <= res_drop;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = out_status_reg;
    assign found_addr_high = out_fh_reg;
    assign found_addr_low  = out_fl_reg;
    assign dropped_count   = out_drop_reg;

    // ---- checks ----
    a_exp_in_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (expires_reg & ~valid_reg) == '0)
        else $error("expiring flag on a free slot");

    a_tick_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.look && (op_reg == MODE_TICK)) |=> $stable(tick_reg))
        else $error("tick counter moved outside a tick");

    a_one_insert: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) <= $countones($past(valid_reg)) + 1)
        else $error("more than one entry filled at once");

endmodule : aamt_dp
`default_nettype wire
